/* sv/jsu_pkg.sv */
// Package for the JSON string unescape unit: item types, run descriptor,
// decode mode codes and byte constants. Used by every module of the block.
// No dependencies.
package jsu_pkg;

  // Default depth of the run queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Reset value of the closing mark (a double quote).
  localparam logic [7:0] QUOTE_RESET = 8'h22;

  // Escape introducer and the escape letters that are recognised.
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;

  // Control characters that the short escapes stand for.
  localparam logic [7:0] VAL_BS = 8'h08;
  localparam logic [7:0] VAL_FF = 8'h0C;
  localparam logic [7:0] VAL_LF = 8'h0A;
  localparam logic [7:0] VAL_CR = 8'h0D;
  localparam logic [7:0] VAL_HT = 8'h09;

  // Hex digit folding and UTF-8 encoding constants.
  localparam logic [7:0]  HEX_ALPHA    = 8'h41;
  localparam logic [7:0]  CASE_BIT     = 8'h20;
  localparam logic [7:0]  DIGIT_ZERO   = 8'h30;
  localparam logic [7:0]  ALPHA_GAP    = 8'h07;
  localparam logic [15:0] CP_ONE_BYTE  = 16'h0080;
  localparam logic [15:0] CP_TWO_BYTE  = 16'h0800;
  localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
  localparam logic [7:0]  UTF8_CONT    = 8'h80;
  localparam logic [7:0]  UTF8_PAYLOAD = 8'h3F;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DATA       = 2'd0,
    ST_CLOSED     = 2'd1,
    ST_BAD_ESCAPE = 2'd2,
    ST_UNCLOSED   = 2'd3
  } jsu_status_t;

  // Decoder mode, one-hot.
  typedef enum logic [5:0] {
    MODE_NORMAL = 6'b000001,
    MODE_ESCAPE = 6'b000010,
    MODE_HEX1   = 6'b000100,
    MODE_HEX2   = 6'b001000,
    MODE_HEX3   = 6'b010000,
    MODE_HEX4   = 6'b100000
  } jsu_mode_t;

  // Input item.
  typedef struct packed {
    logic [7:0] body_byte;
    logic       first_of_string;
    logic       last_in_buffer;
  } jsu_in_t;

  // Result item.
  typedef struct packed {
    logic [7:0]  out_byte;
    jsu_status_t status;
    logic        last_of_run;
  } jsu_out_t;

  // Everything one input item causes: up to three data bytes, then at
  // most one status result.
  typedef struct packed {
    logic [1:0]       n_data;
    logic [2:0][7:0]  data;
    logic             has_tail;
    jsu_status_t      tail_status;
  } jsu_run_t;

  // Low four bits of a hex digit, letters folded to upper case first.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] t;
    logic [7:0] d;
    if (c >= HEX_ALPHA) begin
      t = (c & ~CASE_BIT) - ALPHA_GAP;
    end else begin
      t = c;
    end
    d = t - DIGIT_ZERO;
    return d[3:0];
  endfunction

endpackage

/* sv/jsu_front.sv */
// Front part of the JSON string unescape unit: accepts body bytes, tracks
// the escape state and builds one run descriptor per byte.
// Depends on jsu_pkg.
module jsu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  jsu_pkg::jsu_in_t  in_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  input  logic              q_full,
  output logic              q_push,
  output jsu_pkg::jsu_run_t q_push_run
);

  jsu_pkg::jsu_mode_t mode_r, mode_nxt, mode_cur;
  logic [15:0]        acc_r, acc_nxt, acc_cur;
  logic               fin_r, fin_nxt, fin_cur;
  logic [7:0]         quote_r;
  logic               accept;
  logic [7:0]         b;
  logic [15:0]        cp;
  jsu_pkg::jsu_run_t  run;

  // The single register is always writable.
  assign cfg_ready = 1'b1;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign b        = in_item.body_byte;
  assign cp       = {acc_cur[11:0], jsu_pkg::hex_nibble(b)};

  // Decode one byte into its run of results and the next decoder state.
  always_comb begin
    mode_cur = in_item.first_of_string ? jsu_pkg::MODE_NORMAL : mode_r;
    acc_cur  = in_item.first_of_string ? 16'h0000 : acc_r;
    fin_cur  = in_item.first_of_string ? 1'b0 : fin_r;
    mode_nxt = mode_cur;
    acc_nxt  = acc_cur;
    fin_nxt  = fin_cur;
    run      = '0;
    run.tail_status = jsu_pkg::ST_DATA;
    if (!fin_cur) begin
      case (mode_cur)
        jsu_pkg::MODE_NORMAL: begin
          if (b == jsu_pkg::CH_BACKSLASH) begin
            mode_nxt = jsu_pkg::MODE_ESCAPE;
          end else if (b == quote_r) begin
            run.has_tail    = 1'b1;
            run.tail_status = jsu_pkg::ST_CLOSED;
            fin_nxt         = 1'b1;
          end else begin
            run.n_data  = 2'd1;
            run.data[0] = b;
          end
        end
        jsu_pkg::MODE_ESCAPE: begin
          mode_nxt   = jsu_pkg::MODE_NORMAL;
          run.n_data = 2'd1;
          case (b)
            jsu_pkg::CH_QUOTE:     run.data[0] = jsu_pkg::CH_QUOTE;
            jsu_pkg::CH_BACKSLASH: run.data[0] = jsu_pkg::CH_BACKSLASH;
            jsu_pkg::CH_SLASH:     run.data[0] = jsu_pkg::CH_SLASH;
            jsu_pkg::CH_B:         run.data[0] = jsu_pkg::VAL_BS;
            jsu_pkg::CH_F:         run.data[0] = jsu_pkg::VAL_FF;
            jsu_pkg::CH_N:         run.data[0] = jsu_pkg::VAL_LF;
            jsu_pkg::CH_R:         run.data[0] = jsu_pkg::VAL_CR;
            jsu_pkg::CH_T:         run.data[0] = jsu_pkg::VAL_HT;
            jsu_pkg::CH_U: begin
              run.n_data = 2'd0;
              mode_nxt   = jsu_pkg::MODE_HEX1;
              acc_nxt    = 16'h0000;
            end
            default: begin
              run.n_data      = 2'd0;
              run.has_tail    = 1'b1;
              run.tail_status = jsu_pkg::ST_BAD_ESCAPE;
              fin_nxt         = 1'b1;
            end
          endcase
        end
        jsu_pkg::MODE_HEX1: begin
          acc_nxt  = cp;
          mode_nxt = jsu_pkg::MODE_HEX2;
        end
        jsu_pkg::MODE_HEX2: begin
          acc_nxt  = cp;
          mode_nxt = jsu_pkg::MODE_HEX3;
        end
        jsu_pkg::MODE_HEX3: begin
          acc_nxt  = cp;
          mode_nxt = jsu_pkg::MODE_HEX4;
        end
        jsu_pkg::MODE_HEX4: begin
          // Last digit: encode the code point as UTF-8.
          acc_nxt  = cp;
          mode_nxt = jsu_pkg::MODE_NORMAL;
          if (cp < jsu_pkg::CP_ONE_BYTE) begin
            run.n_data  = 2'd1;
            run.data[0] = cp[7:0];
          end else if (cp < jsu_pkg::CP_TWO_BYTE) begin
            run.n_data  = 2'd2;
            run.data[0] = {3'b000, cp[10:6]} | jsu_pkg::UTF8_LEAD2;
            run.data[1] = (cp[7:0] & jsu_pkg::UTF8_PAYLOAD) | jsu_pkg::UTF8_CONT;
          end else begin
            run.n_data  = 2'd3;
            run.data[0] = {4'b0000, cp[15:12]} | jsu_pkg::UTF8_LEAD3;
            run.data[1] = {2'b00, cp[11:6]} | jsu_pkg::UTF8_CONT;
            run.data[2] = (cp[7:0] & jsu_pkg::UTF8_PAYLOAD) | jsu_pkg::UTF8_CONT;
          end
        end
        default: begin
          run.has_tail    = 1'b1;
          run.tail_status = jsu_pkg::ST_BAD_ESCAPE;
          fin_nxt         = 1'b1;
          mode_nxt        = jsu_pkg::MODE_NORMAL;
        end
      endcase

      // End of the buffer with the string still open.
      if (in_item.last_in_buffer && !fin_nxt) begin
        run.has_tail = 1'b1;
        fin_nxt      = 1'b1;
        if (mode_nxt != jsu_pkg::MODE_NORMAL) begin
          run.tail_status = jsu_pkg::ST_BAD_ESCAPE;
          mode_nxt        = jsu_pkg::MODE_NORMAL;
        end else begin
          run.tail_status = jsu_pkg::ST_UNCLOSED;
        end
      end
    end
  end

  // Only items that cause results go into the queue.
  assign q_push     = accept && ((run.n_data != 2'd0) || run.has_tail);
  assign q_push_run = run;

  // Decoder state and the closing mark.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= jsu_pkg::MODE_NORMAL;
      acc_r   <= 16'h0000;
      fin_r   <= 1'b0;
      quote_r <= jsu_pkg::QUOTE_RESET;
    end else begin
      if (accept) begin
        mode_r <= mode_nxt;
        acc_r  <= acc_nxt;
        fin_r  <= fin_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        quote_r <= cfg_data;
      end
    end
  end

  // A finished string always leaves the decoder outside any escape.
  a_fin_normal: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> (mode_r == jsu_pkg::MODE_NORMAL))
    else $error("string finished while inside an escape");

endmodule

/* sv/jsu_queue.sv */
// Short queue of run descriptors between the front and back parts.
// Depends on jsu_pkg.
module jsu_queue #(
  parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  jsu_pkg::jsu_run_t push_run,
  output logic              full,
  input  logic              pop,
  output jsu_pkg::jsu_run_t head_run,
  output logic              head_valid
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  jsu_pkg::jsu_run_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_run   = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_run;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("run queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("run queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("run queue count beyond depth");

endmodule

/* sv/jsu_back.sv */
// Back part of the JSON string unescape unit: expands each run descriptor
// into result items, one per cycle unless the output stalls, through the
// output register. Depends on jsu_pkg.
module jsu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  jsu_pkg::jsu_run_t head_run,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output jsu_pkg::jsu_out_t out_item
);

  logic [1:0]        sel_r, sel_nxt;
  logic              out_valid_r, out_valid_nxt;
  jsu_pkg::jsu_out_t out_r, res;
  logic              load;
  logic [2:0]        n_total;
  logic              last_res;

  assign n_total  = {1'b0, head_run.n_data} + {2'b00, head_run.has_tail};
  assign last_res = ({1'b0, sel_r} == (n_total - 3'd1));
  assign load     = head_valid && (!out_valid_r || !out_stall);
  assign pop      = load && last_res;

  // Select the current result of the run at the head of the queue.
  always_comb begin
    res = '0;
    if (sel_r < head_run.n_data) begin
      res.out_byte = head_run.data[sel_r];
      res.status   = jsu_pkg::ST_DATA;
    end else begin
      res.out_byte = 8'h00;
      res.status   = head_run.tail_status;
    end
    res.last_of_run = last_res;
  end

  // Step through the run and track the output register.
  always_comb begin
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      sel_nxt       = last_res ? 2'd0 : sel_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Retiring a run always presents its final result next.
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_valid_r && out_r.last_of_run))
    else $error("run retired without its final result");

  // The step counter always rests at zero while nothing is queued.
  a_sel_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> (sel_r == 2'd0))
    else $error("run step counter left mid-run with an empty queue");

endmodule

/* sv/json_string_unescape_unit.sv */
// JSON string unescape unit: decodes quoted string body bytes into UTF-8.
// With nothing waiting, the first result of an item goes through the run queue
// and then the output register. One input item per cycle is taken; an item with
// k results gives them one at a time, and the input stalls only while the run
// queue is full. Reset (rst_n low, synchronous) clears decoder, queue and
// output; the closing mark returns to a double quote. Needs jsu_pkg.
module json_string_unescape_unit #(
  parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  jsu_pkg::jsu_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output jsu_pkg::jsu_out_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_head_valid;
  jsu_pkg::jsu_run_t q_push_run;
  jsu_pkg::jsu_run_t q_head_run;

  // Byte classification and escape decoding.
  jsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_push_run (q_push_run)
  );

  // Runs waiting for the output.
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_run   (q_push_run),
    .full       (q_full),
    .pop        (q_pop),
    .head_run   (q_head_run),
    .head_valid (q_head_valid)
  );

  // Result expansion and output register.
  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_run   (q_head_run),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

/* test/testbench.sv */
// Testbench for json_string_unescape_unit: directed and random string bodies
// are fed through the unit and every result item is checked against a decoder
// kept in this file. Depends on jsu_pkg and json_string_unescape_unit.
module testbench;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  jsu_pkg::jsu_in_t  in_item   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  jsu_pkg::jsu_out_t out_item;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [7:0]        cfg_data  = '0;

  // Decoder state as the unit should hold it.
  logic [7:0]         quote_m   = jsu_pkg::QUOTE_RESET;
  jsu_pkg::jsu_mode_t mode_m    = jsu_pkg::MODE_NORMAL;
  logic [15:0]        hex_acc_m = '0;
  logic               closed_m  = 1'b0;

  jsu_pkg::jsu_out_t run_q[$];
  jsu_pkg::jsu_out_t expected_decoded[$];
  int       decoded_items   = 0;
  int       error_count     = 0;
  int       quiet_cycles    = 0;
  bit       tx_idle         = 1'b1;
  bit       rx_idle         = 1'b1;
  int       hold_off_cycles = 0;
  bit       sink_holding    = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  json_string_unescape_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic emit_result(input logic [7:0] value, input jsu_pkg::jsu_status_t st);
    jsu_pkg::jsu_out_t r;
    r.out_byte    = value;
    r.status      = st;
    r.last_of_run = 1'b0;
    run_q.push_back(r);
  endtask

  task automatic fail_escape();
    emit_result(8'h00, jsu_pkg::ST_BAD_ESCAPE);
    closed_m = 1'b1;
    mode_m   = jsu_pkg::MODE_NORMAL;
  endtask

  // Works out the result items caused by one accepted input item and queues
  // them as expectations.
  task automatic unescape_byte(input jsu_pkg::jsu_in_t it);
    logic [7:0]        b;
    logic [7:0]        folded;
    logic [15:0]       cp;
    jsu_pkg::jsu_out_t r;
    b = it.body_byte;
    run_q.delete();
    if (it.first_of_string) begin
      mode_m    = jsu_pkg::MODE_NORMAL;
      hex_acc_m = '0;
      closed_m  = 1'b0;
    end
    if (closed_m) return;
    decoded_items++;

    case (mode_m)
      jsu_pkg::MODE_NORMAL: begin
        if (b == jsu_pkg::CH_BACKSLASH) begin
          mode_m = jsu_pkg::MODE_ESCAPE;
        end else if (b == quote_m) begin
          emit_result(8'h00, jsu_pkg::ST_CLOSED);
          closed_m = 1'b1;
        end else begin
          emit_result(b, jsu_pkg::ST_DATA);
        end
      end
      jsu_pkg::MODE_ESCAPE: begin
        mode_m = jsu_pkg::MODE_NORMAL;
        case (b)
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH:
            emit_result(b, jsu_pkg::ST_DATA);
          jsu_pkg::CH_B: emit_result(jsu_pkg::VAL_BS, jsu_pkg::ST_DATA);
          jsu_pkg::CH_F: emit_result(jsu_pkg::VAL_FF, jsu_pkg::ST_DATA);
          jsu_pkg::CH_N: emit_result(jsu_pkg::VAL_LF, jsu_pkg::ST_DATA);
          jsu_pkg::CH_R: emit_result(jsu_pkg::VAL_CR, jsu_pkg::ST_DATA);
          jsu_pkg::CH_T: emit_result(jsu_pkg::VAL_HT, jsu_pkg::ST_DATA);
          jsu_pkg::CH_U: begin
            mode_m    = jsu_pkg::MODE_HEX1;
            hex_acc_m = '0;
          end
          default: fail_escape();
        endcase
      end
      default: begin
        // Hex digit: letters lose their case bit and are moved down to follow
        // the digits; only the low four bits count, valid or not.
        folded = (b >= jsu_pkg::HEX_ALPHA) ?
                 ((b & ~jsu_pkg::CASE_BIT) - jsu_pkg::ALPHA_GAP) : b;
        folded = folded - jsu_pkg::DIGIT_ZERO;
        cp = {hex_acc_m[11:0], folded[3:0]};
        hex_acc_m = cp;
        if (mode_m != jsu_pkg::MODE_HEX4) begin
          mode_m = jsu_pkg::jsu_mode_t'(mode_m << 1);
        end else begin
          mode_m = jsu_pkg::MODE_NORMAL;
          if (cp < jsu_pkg::CP_ONE_BYTE) begin
            emit_result(cp[7:0], jsu_pkg::ST_DATA);
          end else if (cp < jsu_pkg::CP_TWO_BYTE) begin
            emit_result(jsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]}, jsu_pkg::ST_DATA);
            emit_result(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]}, jsu_pkg::ST_DATA);
          end else begin
            emit_result(jsu_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]}, jsu_pkg::ST_DATA);
            emit_result(jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]}, jsu_pkg::ST_DATA);
            emit_result(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]}, jsu_pkg::ST_DATA);
          end
        end
      end
    endcase

    // End of the buffer: a cut escape is an error, an open string is flagged.
    if (it.last_in_buffer && !closed_m) begin
      if (mode_m != jsu_pkg::MODE_NORMAL) begin
        fail_escape();
      end else begin
        emit_result(8'h00, jsu_pkg::ST_UNCLOSED);
        closed_m = 1'b1;
      end
    end

    if (run_q.size() > 0) begin
      r = run_q.pop_back();
      r.last_of_run = 1'b1;
      run_q.push_back(r);
    end
    foreach (run_q[k]) expected_decoded.push_back(run_q[k]);
  endtask

  // Offers one item, after an optional gap, and holds it until accepted.
  task automatic send_item(input jsu_pkg::jsu_in_t it);
    int gap;
    gap = tx_idle ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    unescape_byte(it);
  endtask

  task automatic send_body(input logic [7:0] b, input bit first, input bit last);
    jsu_pkg::jsu_in_t it;
    it.body_byte       = b;
    it.first_of_string = first;
    it.last_in_buffer  = last;
    send_item(it);
  endtask

  // Stops sending and waits until every expected result has arrived, plus a
  // settling wait (SETTLE_CYCLES) for items still in flight that cause no result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_decoded.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_quote(input logic [7:0] mark);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= mark;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    quote_m = mark;
  endtask

  // One string body built from random tokens: plain bytes, short escapes,
  // unicode escapes and the odd bad escape, then one of several endings.
  task automatic send_string();
    logic [7:0]  text[$];
    logic [15:0] cp;
    logic [3:0]  nib;
    logic [7:0]  ch;
    int          tokens;
    int          shape;
    int          ending;
    int          span;
    bit          end_flag;
    tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6);
    for (int t = 0; t < tokens; t++) begin
      shape = $urandom_range(0, 99);
      if (shape < 45) begin
        do ch = 8'($urandom_range(0, 255));
        while (ch == jsu_pkg::CH_BACKSLASH || ch == quote_m);
        text.push_back(ch);
      end else if (shape < 70) begin
        case ($urandom_range(0, 7))
          0: ch = jsu_pkg::CH_QUOTE;
          1: ch = jsu_pkg::CH_BACKSLASH;
          2: ch = jsu_pkg::CH_SLASH;
          3: ch = jsu_pkg::CH_B;
          4: ch = jsu_pkg::CH_F;
          5: ch = jsu_pkg::CH_N;
          6: ch = jsu_pkg::CH_R;
          default: ch = jsu_pkg::CH_T;
        endcase
        text.push_back(jsu_pkg::CH_BACKSLASH);
        text.push_back(ch);
      end else if (shape < 94) begin
        // Code point drawn so that one, two and three byte forms all occur.
        span = $urandom_range(0, 2);
        if (span == 0) cp = 16'($urandom_range(0, 16'h007F));
        else if (span == 1) cp = 16'($urandom_range(16'h0080, 16'h07FF));
        else cp = 16'($urandom_range(16'h0800, 16'hFFFF));
        text.push_back(jsu_pkg::CH_BACKSLASH);
        text.push_back(jsu_pkg::CH_U);
        for (int d = 3; d >= 0; d--) begin
          nib = cp[4*d +: 4];
          if ($urandom_range(0, 9) == 0) ch = 8'($urandom_range(0, 255));
          else if (nib < 10) ch = jsu_pkg::DIGIT_ZERO + nib;
          else ch = ($urandom_range(0, 1) ? jsu_pkg::HEX_ALPHA :
                     (jsu_pkg::HEX_ALPHA | jsu_pkg::CASE_BIT)) + nib - 8'd10;
          text.push_back(ch);
        end
      end else begin
        ch = 8'($urandom_range(0, 255));
        text.push_back(jsu_pkg::CH_BACKSLASH);
        text.push_back(ch);
      end
    end

    ending   = $urandom_range(0, 99);
    end_flag = 1'b0;
    if (ending < 60) begin
      // Closed by the mark, sometimes with bytes after it that are ignored.
      text.push_back(quote_m);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          ch = 8'($urandom_range(0, 255));
          text.push_back(ch);
        end
      end
      end_flag = ($urandom_range(0, 3) == 0);
    end else if (ending < 82) begin
      end_flag = 1'b1;
    end else if (ending < 92) begin
      // Buffer ends part way through an escape.
      text.push_back(jsu_pkg::CH_BACKSLASH);
      if ($urandom_range(0, 1)) begin
        text.push_back(jsu_pkg::CH_U);
        repeat ($urandom_range(0, 3)) begin
          ch = jsu_pkg::DIGIT_ZERO + 8'($urandom_range(0, 9));
          text.push_back(ch);
        end
      end
      end_flag = 1'b1;
    end
    // Otherwise the string is abandoned and the next one starts afresh.

    if (text.size() == 0) begin
      ch = 8'($urandom_range(0, 255));
      text.push_back(ch);
    end
    foreach (text[k]) send_body(text[k], k == 0, end_flag && (k == text.size() - 1));
  endtask

  // A few items with every field random.
  task automatic send_noise();
    jsu_pkg::jsu_in_t it;
    repeat ($urandom_range(1, 6)) begin
      it = jsu_pkg::jsu_in_t'(10'($urandom_range(0, 1023)));
      send_item(it);
    end
  endtask

  // Field extremes and each special case, with the closing mark at reset.
  task automatic test_directed();
    // Plain bytes at both ends of the range.
    send_body(8'h41, 1'b1, 1'b0);
    send_body(8'h00, 1'b0, 1'b0);
    send_body(8'hFF, 1'b0, 1'b0);
    // Short escape for a line feed.
    send_body(jsu_pkg::CH_BACKSLASH, 1'b0, 1'b0);
    send_body(jsu_pkg::CH_N, 1'b0, 1'b0);
    // Two-byte code point written with lower-case digits, 00e9.
    send_body(jsu_pkg::CH_BACKSLASH, 1'b0, 1'b0);
    send_body(jsu_pkg::CH_U, 1'b0, 1'b0);
    send_body(8'h30, 1'b0, 1'b0);
    send_body(8'h30, 1'b0, 1'b0);
    send_body(8'h65, 1'b0, 1'b0);
    send_body(8'h39, 1'b0, 1'b0);
    // Largest code point as the last byte of the buffer: three data bytes
    // followed by the unclosed flag.
    send_body(jsu_pkg::CH_BACKSLASH, 1'b0, 1'b0);
    send_body(jsu_pkg::CH_U, 1'b0, 1'b0);
    send_body(8'h46, 1'b0, 1'b0);
    send_body(8'h46, 1'b0, 1'b0);
    send_body(8'h66, 1'b0, 1'b0);
    send_body(8'h46, 1'b0, 1'b1);
    // New string with an unknown escape letter, then a byte to be ignored.
    send_body(jsu_pkg::CH_BACKSLASH, 1'b1, 1'b0);
    send_body(8'h78, 1'b0, 1'b0);
    send_body(8'h71, 1'b0, 1'b0);
    // Empty string closed at once, then an ignored byte.
    send_body(jsu_pkg::CH_QUOTE, 1'b1, 1'b0);
    send_body(8'h7A, 1'b0, 1'b0);
    // Buffer ending inside a unicode escape.
    send_body(jsu_pkg::CH_BACKSLASH, 1'b1, 1'b0);
    send_body(jsu_pkg::CH_U, 1'b0, 1'b0);
    send_body(8'h31, 1'b0, 1'b1);
  endtask

  task automatic test_random_strings(input logic [7:0] mark, input int item_goal,
                                     input bit tx_gaps, input bit rx_gaps);
    write_quote(mark);
    tx_idle       = tx_gaps;
    rx_idle       = rx_gaps;
    decoded_items = 0;
    while (decoded_items < item_goal) begin
      if ($urandom_range(0, 11) == 0) send_noise();
      else send_string();
    end
  endtask

  // The sink holds off while three-byte code points keep arriving, so the
  // unit fills up and stalls its input; then the sender waits for the drain.
  task automatic test_backpressure();
    write_quote(jsu_pkg::QUOTE_RESET);
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    hold_off_cycles = HOLD_CYCLES;
    wait (sink_holding);
    send_body(8'h61, 1'b1, 1'b0);
    repeat (6) begin
      send_body(jsu_pkg::CH_BACKSLASH, 1'b0, 1'b0);
      send_body(jsu_pkg::CH_U, 1'b0, 1'b0);
      send_body(8'h45, 1'b0, 1'b0);
      repeat (3) send_body(jsu_pkg::DIGIT_ZERO + 8'($urandom_range(0, 9)), 1'b0, 1'b0);
    end
    send_body(jsu_pkg::QUOTE_RESET, 1'b0, 1'b0);
    wait_idle();
  endtask

  // Result sink: random stalls, a long hold when one is requested.
  initial begin : result_sink
    int n;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
        sink_holding = 1'b1;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        sink_holding = 1'b0;
      end else if (!rx_idle) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        n = idle_length();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  // Each accepted result item is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    jsu_pkg::jsu_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_decoded.size() == 0) begin
        $error("result with none expected: out_byte %02h status %0d",
               out_item.out_byte, out_item.status);
        error_count++;
      end else begin
        want = expected_decoded.pop_front();
        if (out_item.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_item.out_byte);
          error_count++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          error_count++;
        end
        if (out_item.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run, out_item.last_of_run);
          error_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no channel has moved an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : run
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_strings(jsu_pkg::QUOTE_RESET, 120, 1'b1, 1'b1);
    test_random_strings(8'h00, 60, 1'b1, 1'b1);
    test_random_strings(8'hFF, 60, 1'b0, 1'b0);
    test_random_strings(jsu_pkg::CH_BACKSLASH, 50, 1'b1, 1'b1);
    test_random_strings(8'h27, 60, 1'b1, 1'b0);
    test_backpressure();
    test_random_strings(jsu_pkg::QUOTE_RESET, 80, 1'b1, 1'b1);
    wait_idle();
    if (error_count == 0 && expected_decoded.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
